FILE: src/fph_pkg.sv
// Package for the fit-policy hole allocator: codes, widths, the scan token
// and the update command shared by the top level and the slot cells.
// No dependencies.
package fph_pkg;

	localparam int ADDR_W        = 16;
	localparam int IDX_W         = 8;
	localparam int MAX_HOLES_DEF = 16;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_ALLOC = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic [1:0] POL_BEST  = 2'd0;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ADD,
		OP_PLACE
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY
	} state_t;

	// travels down the cell row, one cell per cycle
	typedef struct packed {
		logic              fit;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		logic [IDX_W-1:0]  pick;
		logic              wfree;
		logic [IDX_W-1:0]  widx;
		logic              cfree;
		logic [IDX_W-1:0]  cidx;
	} tok_t;

	// broadcast to every cell in the update cycle
	typedef struct packed {
		op_t               op;
		logic              commit;
		logic              rollback;
		logic [IDX_W-1:0]  widx;
		logic [IDX_W-1:0]  cidx;
		logic [IDX_W-1:0]  pick;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] amt;
	} upd_t;

endpackage

FILE: src/fit_policy_hole_allocator_top.sv
// Top level of the fit-policy hole allocator: control FSM and a row of
// slot cells. Depends on fph_pkg and fph_cell.
//
//  channel | signals                                     | handshake
//  request | start, req_type, hole_base, amount,          | start && !busy
//          | last_of_process                             |
//  result  | done, status, placed_base, process_done,    | done, one cycle
//          | process_ok                                  |
//  config  | cfg_we, cfg_data                            | cfg_we
//
// For each item the scan token walks the cell row one cell per cycle, then
// the update state applies the change, and the result shows the cycle
// after. A new item may start in the cycle its result is shown.
// Reset empties both tables and selects best fit. The receiver cannot stall.
module fit_policy_hole_allocator_top #(
	parameter int MAX_HOLES = fph_pkg::MAX_HOLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 req_type,
	input  logic [fph_pkg::ADDR_W-1:0] hole_base,
	input  logic [fph_pkg::ADDR_W-1:0] amount,
	input  logic                       last_of_process,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_data,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [fph_pkg::ADDR_W-1:0] placed_base,
	output logic                       process_done,
	output logic                       process_ok
);
	import fph_pkg::*;

	localparam int CNT_W = $clog2(MAX_HOLES);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        policy_q;
	req_t              req_q;
	logic [ADDR_W-1:0] base_q, amt_q;
	logic              last_q, failed_q, failed_d;
	logic [1:0]        stat_d;
	logic [ADDR_W-1:0] placed_d;
	logic              pdone_d, pok_d;
	upd_t              upd;
	tok_t              tok [MAX_HOLES];
	tok_t              tk;

	genvar g;
	generate
		for (g = 0; g < MAX_HOLES; g++) begin : g_cell
			fph_cell #(.IDX(g)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.policy (policy_q),
				.amt    (amt_q),
				.tok_in ((g == 0) ? tok_t'('0) : tok[(g == 0) ? 0 : g-1]),
				.upd    (upd),
				.tok_q  (tok[g])
			);
		end
	endgenerate

	assign tk   = tok[MAX_HOLES-1];
	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		failed_d  = failed_q;
		stat_d    = STAT_DONE;
		placed_d  = '0;
		pdone_d   = 1'b0;
		pok_d     = 1'b0;
		upd       = '0;
		upd.op    = OP_NONE;
		upd.widx  = tk.widx;
		upd.cidx  = tk.cidx;
		upd.pick  = tk.pick;
		upd.base  = base_q;
		upd.amt   = amt_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_SCAN;
			S_SCAN: if (cnt_q == CNT_W'(MAX_HOLES - 1)) state_d = S_APPLY;
			S_APPLY: begin
				state_d = S_IDLE;
				unique case (req_q)
					REQ_CLEAR: begin
						upd.op   = OP_CLEAR;
						failed_d = 1'b0;
					end
					REQ_ADD: begin
						if (tk.wfree && tk.cfree) upd.op = OP_ADD;
						else stat_d = STAT_FULL;
					end
					REQ_ALLOC: begin
						if (tk.fit) begin
							upd.op   = OP_PLACE;
							placed_d = tk.base;
						end else begin
							stat_d = STAT_NOFIT;
						end
						if (last_q) begin
							pdone_d      = 1'b1;
							pok_d        = !failed_q && tk.fit;
							upd.commit   = pok_d;
							upd.rollback = !pok_d;
							failed_d     = 1'b0;
						end else begin
							failed_d = failed_q || !tk.fit;
						end
					end
					default: ;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			policy_q <= POL_BEST;
			failed_q <= 1'b0;
			done     <= 1'b0;
		end else begin
			state_q  <= state_d;
			failed_q <= failed_d;
			done     <= (state_q == S_APPLY);
			if (cfg_we) policy_q <= cfg_data;
			if (state_q == S_SCAN) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q  <= req_t'(req_type);
			base_q <= hole_base;
			amt_q  <= amount;
			last_q <= last_of_process;
		end
		if (state_q == S_APPLY) begin
			status       <= stat_d;
			placed_base  <= placed_d;
			process_done <= pdone_d;
			process_ok   <= pok_d;
		end
	end

endmodule

FILE: src/fph_cell.sv
// One hole slot: working and committed entry, plus one stage of the scan.
// Depends on fph_pkg.
module fph_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 policy,
	input  logic [fph_pkg::ADDR_W-1:0] amt,
	input  fph_pkg::tok_t              tok_in,
	input  fph_pkg::upd_t              upd,
	output fph_pkg::tok_t              tok_q
);
	import fph_pkg::*;

	localparam logic [IDX_W-1:0] MY = IDX_W'(IDX);

	logic              wv_q, cv_q, nwv, ncv, fits, better;
	logic [ADDR_W-1:0] wb_q, ws_q, cb_q, cs_q, nwb, nws, ncb, ncs;
	tok_t              tok_d;

	always_comb begin
		fits = wv_q && (ws_q >= amt);
		if (policy == POL_BEST && ws_q != tok_in.size)
			better = ws_q < tok_in.size;
		else if (policy == POL_WORST && ws_q != tok_in.size)
			better = ws_q > tok_in.size;
		else
			better = wb_q < tok_in.base;
		tok_d = tok_in;
		if (fits && (!tok_in.fit || better)) begin
			tok_d.fit  = 1'b1;
			tok_d.base = wb_q;
			tok_d.size = ws_q;
			tok_d.pick = MY;
		end
		if (!wv_q && !tok_in.wfree) begin
			tok_d.wfree = 1'b1;
			tok_d.widx  = MY;
		end
		if (!cv_q && !tok_in.cfree) begin
			tok_d.cfree = 1'b1;
			tok_d.cidx  = MY;
		end
	end

	always_comb begin
		nwv = wv_q; nwb = wb_q; nws = ws_q;
		ncv = cv_q; ncb = cb_q; ncs = cs_q;
		case (upd.op)
			OP_CLEAR: begin
				nwv = 1'b0;
				ncv = 1'b0;
			end
			OP_ADD: begin
				if (upd.widx == MY) begin
					nwv = 1'b1; nwb = upd.base; nws = upd.amt;
				end
				if (upd.cidx == MY) begin
					ncv = 1'b1; ncb = upd.base; ncs = upd.amt;
				end
			end
			OP_PLACE: begin
				if (upd.pick == MY) begin
					if (ws_q == upd.amt) begin
						nwv = 1'b0;
					end else begin
						nwb = wb_q + upd.amt;
						nws = ws_q - upd.amt;
					end
				end
			end
			default: ;
		endcase
		if (upd.commit) begin
			ncv = nwv; ncb = nwb; ncs = nws;
		end
		if (upd.rollback) begin
			nwv = cv_q; nwb = cb_q; nws = cs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q <= 1'b0;
			cv_q <= 1'b0;
		end else begin
			wv_q <= nwv;
			cv_q <= ncv;
		end
	end

	always_ff @(posedge clk) begin
		wb_q  <= nwb;
		ws_q  <= nws;
		cb_q  <= ncb;
		cs_q  <= ncs;
		tok_q <= tok_d;
	end

endmodule

FILE: src/fph_checker.sv
// Port-level checks for the fit-policy hole allocator, bound to the top.
// Depends on fph_pkg and fit_policy_hole_allocator_top.
module fph_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [1:0]                 status,
	input logic [fph_pkg::ADDR_W-1:0] placed_base,
	input logic                       process_done,
	input logic                       process_ok
);
	import fph_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !$past(done)) else $error("result without work");

	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		done && process_ok |-> process_done) else $error("ok without close");

	a_nofit_base: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_DONE |-> placed_base == '0 && !process_ok)
		else $error("failed item shows a base or ok");

endmodule

bind fit_policy_hole_allocator_top fph_checker u_fph_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.placed_base  (placed_base),
	.process_done (process_done),
	.process_ok   (process_ok)
);
